### rtl/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
package qrs_pkg;

   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   typedef enum logic [1:0] {
      STATUS_TWO      = 2'd0,
      STATUS_SINGLE   = 2'd1,
      STATUS_NEG_DISC = 2'd2,
      STATUS_DEGEN    = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } meta_type;

endpackage

### rtl/qrs_disc.sv
// Front end: coefficient magnitudes, split products, discriminant and case selection.
module qrs_disc #(
   parameter int W = qrs_pkg::COEF_WIDTH,
   parameter int F = qrs_pkg::FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        up_valid,
   input  logic signed [W-1:0]         up_a,
   input  logic signed [W-1:0]         up_b,
   input  logic signed [W-1:0]         up_c,
   output qrs_pkg::meta_type           down_meta,
   output logic [2*W:0]                down_dmag,
   output logic signed [W+F:0]         down_base,
   output logic [W:0]                  down_den,
   output logic                        down_den_neg
);

   localparam int H  = (W + 1) / 2;
   localparam int HW = W - H;
   localparam int DW = 2 * W + 1;
   localparam int BW = W + F + 1;
   localparam int PW = 2 * W;

   logic [W-1:0] mag_a, mag_b, mag_c;
   logic         linear;
   logic signed [BW-1:0] sel_ext;
   logic signed [BW-1:0] base_in;
   logic [W:0]           den_in;

   // Stage 1 registers
   logic              v1_ff;
   logic [2*H-1:0]    bb_ll_ff, ac_ll_ff;
   logic [W-1:0]      bb_lh_ff, ac_lh_ff, ac_hl_ff;
   logic [2*HW-1:0]   bb_hh_ff, ac_hh_ff;
   logic              ac_neg1_ff, a_zero1_ff, b_zero1_ff;
   logic signed [BW-1:0] base1_ff;
   logic [W:0]        den1_ff;
   logic              den_neg1_ff;

   // Stage 2 registers
   logic              v2_ff;
   logic [PW-1:0]     bb_ff, ac_ff;
   logic              ac_neg2_ff, a_zero2_ff, b_zero2_ff;
   logic signed [BW-1:0] base2_ff;
   logic [W:0]        den2_ff;
   logic              den_neg2_ff;

   logic [PW-1:0]     bb_in, ac_in;

   // Stage 3 registers
   qrs_pkg::meta_type meta3_ff;
   logic [DW-1:0]     dmag3_ff;
   logic signed [BW-1:0] base3_ff;
   logic [W:0]        den3_ff;
   logic              den_neg3_ff;

   logic [DW:0]       four_ac;
   logic [DW:0]       d_val;
   logic [DW-1:0]     dmag_in;
   qrs_pkg::status_type status_in;

   assign mag_a = up_a[W-1] ? $unsigned(-up_a) : $unsigned(up_a);
   assign mag_b = up_b[W-1] ? $unsigned(-up_b) : $unsigned(up_b);
   assign mag_c = up_c[W-1] ? $unsigned(-up_c) : $unsigned(up_c);

   // With a zero the block solves the linear case -c/b.
   assign linear  = (up_a == '0);
   assign sel_ext = linear ? BW'(up_c) : BW'(up_b);
   assign base_in = -(sel_ext <<< F);
   assign den_in  = linear ? {1'b0, mag_b} : {mag_a, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         meta3_ff <= '0;
      end else if (en) begin
         v1_ff <= up_valid;
         v2_ff <= v1_ff;
         meta3_ff.valid <= v2_ff;
         meta3_ff.status <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb_ll_ff    <= mag_b[H-1:0] * mag_b[H-1:0];
         bb_lh_ff    <= mag_b[H-1:0] * mag_b[W-1:H];
         bb_hh_ff    <= mag_b[W-1:H] * mag_b[W-1:H];
         ac_ll_ff    <= mag_a[H-1:0] * mag_c[H-1:0];
         ac_lh_ff    <= mag_a[H-1:0] * mag_c[W-1:H];
         ac_hl_ff    <= mag_a[W-1:H] * mag_c[H-1:0];
         ac_hh_ff    <= mag_a[W-1:H] * mag_c[W-1:H];
         ac_neg1_ff  <= up_a[W-1] ^ up_c[W-1];
         a_zero1_ff  <= linear;
         b_zero1_ff  <= (up_b == '0);
         base1_ff    <= base_in;
         den1_ff     <= den_in;
         den_neg1_ff <= linear ? up_b[W-1] : up_a[W-1];

         bb_ff       <= bb_in;
         ac_ff       <= ac_in;
         ac_neg2_ff  <= ac_neg1_ff;
         a_zero2_ff  <= a_zero1_ff;
         b_zero2_ff  <= b_zero1_ff;
         base2_ff    <= base1_ff;
         den2_ff     <= den1_ff;
         den_neg2_ff <= den_neg1_ff;

         dmag3_ff    <= dmag_in;
         base3_ff    <= base2_ff;
         den3_ff     <= den2_ff;
         den_neg3_ff <= den_neg2_ff;
      end
   end

   assign bb_in = (PW'(bb_hh_ff) << (2 * H)) + (PW'(bb_lh_ff) << (H + 1)) + PW'(bb_ll_ff);
   assign ac_in = (PW'(ac_hh_ff) << (2 * H)) + ((PW'(ac_lh_ff) + PW'(ac_hl_ff)) << H)
                  + PW'(ac_ll_ff);

   assign four_ac = (DW + 1)'(ac_ff) << 2;
   assign d_val   = ac_neg2_ff ? ((DW + 1)'(bb_ff) + four_ac) : ((DW + 1)'(bb_ff) - four_ac);
   assign dmag_in = d_val[DW] ? '0 : d_val[DW-1:0];

   always_comb begin
      if (d_val[DW]) begin
         status_in = qrs_pkg::STATUS_NEG_DISC;
      end else if (a_zero2_ff && b_zero2_ff) begin
         status_in = qrs_pkg::STATUS_DEGEN;
      end else if (a_zero2_ff || (d_val == '0)) begin
         status_in = qrs_pkg::STATUS_SINGLE;
      end else begin
         status_in = qrs_pkg::STATUS_TWO;
      end
   end

   assign down_meta    = meta3_ff;
   assign down_dmag    = dmag3_ff;
   assign down_base    = base3_ff;
   assign down_den     = den3_ff;
   assign down_den_neg = den_neg3_ff;

endmodule

### rtl/qrs_sqrt_cell.sv
// One restoring square root cell: settles one root bit per transaction per cycle while en is high.
module qrs_sqrt_cell #(
   parameter int RW = qrs_pkg::COEF_WIDTH + qrs_pkg::FRAC_BITS + 1,
   parameter int PW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  qrs_pkg::meta_type   up_meta,
   input  logic [PW-1:0]       up_pass,
   input  logic [2*RW-1:0]     up_rad,
   input  logic [RW+1:0]       up_rem,
   input  logic [RW-1:0]       up_root,
   output qrs_pkg::meta_type   down_meta,
   output logic [PW-1:0]       down_pass,
   output logic [2*RW-1:0]     down_rad,
   output logic [RW+1:0]       down_rem,
   output logic [RW-1:0]       down_root
);

   localparam int NW = 2 * RW;

   qrs_pkg::meta_type meta_ff;
   logic [PW-1:0]   pass_ff;
   logic [NW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [RW+3:0]   rem_sh, trial;
   logic            ge;

   // Bring down the next two radicand bits and try the root bit as one.
   assign rem_sh  = {up_rem, up_rad[NW-1:NW-2]};
   assign trial   = (RW + 4)'({up_root, 2'b01});
   assign ge      = (rem_sh >= trial);
   assign rem_in  = ge ? (RW + 2)'(rem_sh - trial) : rem_sh[RW+1:0];
   assign root_in = {up_root[RW-2:0], ge};
   assign rad_in  = up_rad << 2;

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else if (en) begin
         meta_ff <= up_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pass_ff <= up_pass;
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign down_meta = meta_ff;
   assign down_pass = pass_ff;
   assign down_rad  = rad_ff;
   assign down_rem  = rem_ff;
   assign down_root = root_ff;

endmodule

### rtl/qrs_div_cell.sv
// One restoring division cell for both root lanes: one quotient bit per cycle while en is high.
module qrs_div_cell #(
   parameter int NUMW = qrs_pkg::COEF_WIDTH + qrs_pkg::FRAC_BITS + 2,
   parameter int DENW = qrs_pkg::COEF_WIDTH + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  qrs_pkg::meta_type   up_meta,
   input  logic [1:0]          up_neg,
   input  logic [DENW-1:0]     up_den,
   input  logic [NUMW-1:0]     up_num1,
   input  logic [NUMW-1:0]     up_num2,
   input  logic [DENW-1:0]     up_rem1,
   input  logic [DENW-1:0]     up_rem2,
   input  logic [NUMW-1:0]     up_q1,
   input  logic [NUMW-1:0]     up_q2,
   output qrs_pkg::meta_type   down_meta,
   output logic [1:0]          down_neg,
   output logic [DENW-1:0]     down_den,
   output logic [NUMW-1:0]     down_num1,
   output logic [NUMW-1:0]     down_num2,
   output logic [DENW-1:0]     down_rem1,
   output logic [DENW-1:0]     down_rem2,
   output logic [NUMW-1:0]     down_q1,
   output logic [NUMW-1:0]     down_q2
);

   qrs_pkg::meta_type meta_ff;
   logic [1:0]      neg_ff;
   logic [DENW-1:0] den_ff;
   logic [NUMW-1:0] num1_ff, num2_ff, num1_in, num2_in;
   logic [DENW-1:0] rem1_ff, rem2_ff, rem1_in, rem2_in;
   logic [NUMW-1:0] q1_ff, q2_ff, q1_in, q2_in;

   // Returns {quotient bit, new remainder}.
   function automatic logic [DENW:0] div_step(input logic [DENW-1:0] rem,
                                              input logic             nbit,
                                              input logic [DENW-1:0] den);
      logic [DENW:0] sh;
      logic          ge;
      sh = {rem, nbit};
      ge = (sh >= {1'b0, den});
      return ge ? {1'b1, DENW'(sh - {1'b0, den})} : {1'b0, sh[DENW-1:0]};
   endfunction

   logic [DENW:0] st1, st2;

   assign st1     = div_step(up_rem1, up_num1[NUMW-1], up_den);
   assign st2     = div_step(up_rem2, up_num2[NUMW-1], up_den);
   assign rem1_in = st1[DENW-1:0];
   assign rem2_in = st2[DENW-1:0];
   assign q1_in   = {up_q1[NUMW-2:0], st1[DENW]};
   assign q2_in   = {up_q2[NUMW-2:0], st2[DENW]};
   assign num1_in = up_num1 << 1;
   assign num2_in = up_num2 << 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else if (en) begin
         meta_ff <= up_meta;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= up_neg;
         den_ff  <= up_den;
         num1_ff <= num1_in;
         num2_ff <= num2_in;
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         q1_ff   <= q1_in;
         q2_ff   <= q2_in;
      end
   end

   assign down_meta = meta_ff;
   assign down_neg  = neg_ff;
   assign down_den  = den_ff;
   assign down_num1 = num1_ff;
   assign down_num2 = num2_ff;
   assign down_rem1 = rem1_ff;
   assign down_rem2 = rem2_ff;
   assign down_q1   = q1_ff;
   assign down_q2   = q2_ff;

endmodule

### rtl/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver with output skid buffer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_coef_a, req_coef_b, req_coef_c
//   rsp      out        rsp_valid/rsp_stall   rsp_root_first, rsp_root_second,
//                                             rsp_root_count, rsp_status, rsp_saturated
//
// One transaction enters per cycle while req_stall is low. Results pass through the
// square root chain (one cell per root bit) and the division chain
// (one cell per quotient bit). Reset is synchronous and empties the pipeline.
// When rsp is stalled, one extra result parks in the skid register; req_stall rises
// only once that register is full, and the whole pipeline then holds.
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COEF_WIDTH-1:0] rsp_root_first,
   output logic signed [COEF_WIDTH-1:0] rsp_root_second,
   output logic [1:0]                   rsp_root_count,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_saturated
);

   localparam int W    = COEF_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DW   = 2 * W + 1;
   localparam int BW   = W + F + 1;
   localparam int DENW = W + 1;
   localparam int RW   = W + F + 1;
   localparam int NW   = 2 * RW;
   localparam int SPW  = BW + DENW + 1;
   localparam int XW   = W + F + 3;
   localparam int NUMW = W + F + 2;
   localparam int RESW = 2 * W + 5;
   localparam logic [NUMW-1:0] LIM = NUMW'(1) << (W - 1);

   logic en;
   logic rsp_valid_ff, skid_valid_ff;

   qrs_pkg::meta_type   front_meta;
   logic [DW-1:0]       front_dmag;
   logic signed [BW-1:0] front_base;
   logic [DENW-1:0]     front_den;
   logic                front_den_neg;

   assign en = ~skid_valid_ff;

   qrs_disc #(.W(W), .F(F)) u_disc (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .up_valid     (req_valid),
      .up_a         (req_coef_a),
      .up_b         (req_coef_b),
      .up_c         (req_coef_c),
      .down_meta    (front_meta),
      .down_dmag    (front_dmag),
      .down_base    (front_base),
      .down_den     (front_den),
      .down_den_neg (front_den_neg)
   );

   // Square root chain over the discriminant scaled by two fraction widths.
   qrs_pkg::meta_type sq_meta [0:RW];
   logic [SPW-1:0]    sq_pass [0:RW];
   logic [NW-1:0]     sq_rad  [0:RW];
   logic [RW+1:0]     sq_rem  [0:RW];
   logic [RW-1:0]     sq_root [0:RW];

   assign sq_meta[0] = front_meta;
   assign sq_pass[0] = {front_base, front_den, front_den_neg};
   assign sq_rad[0]  = NW'(front_dmag) << (2 * F);
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_meta   (sq_meta[i]),
         .up_pass   (sq_pass[i]),
         .up_rad    (sq_rad[i]),
         .up_rem    (sq_rem[i]),
         .up_root   (sq_root[i]),
         .down_meta (sq_meta[i+1]),
         .down_pass (sq_pass[i+1]),
         .down_rad  (sq_rad[i+1]),
         .down_rem  (sq_rem[i+1]),
         .down_root (sq_root[i+1])
      );
   end

   // Numerators: -b*2^F plus and minus the root, or the single-root numerator twice.
   logic signed [BW-1:0] sq_base;
   logic [DENW-1:0]      sq_den;
   logic                 sq_den_neg;
   logic signed [XW-1:0] base_x, s_x, x1_in, x2_in;

   assign {sq_base, sq_den, sq_den_neg} = sq_pass[RW];
   assign base_x = XW'(sq_base);
   assign s_x    = (sq_meta[RW].status == qrs_pkg::STATUS_TWO) ?
                   $signed({2'b00, sq_root[RW]}) : '0;
   assign x1_in  = base_x + s_x;
   assign x2_in  = base_x - s_x;

   qrs_pkg::meta_type    meta_a_ff;
   logic signed [XW-1:0] x1_a_ff, x2_a_ff;
   logic [DENW-1:0]      den_a_ff;
   logic                 den_neg_a_ff;

   qrs_pkg::meta_type    meta_b_ff;
   logic [NUMW-1:0]      mag1_b_ff, mag2_b_ff, mag1_in, mag2_in;
   logic [1:0]           neg_b_ff, neg_in;
   logic [DENW-1:0]      den_b_ff;

   assign mag1_in = x1_a_ff[XW-1] ? NUMW'(-x1_a_ff) : NUMW'(x1_a_ff);
   assign mag2_in = x2_a_ff[XW-1] ? NUMW'(-x2_a_ff) : NUMW'(x2_a_ff);
   assign neg_in  = {x1_a_ff[XW-1] ^ den_neg_a_ff, x2_a_ff[XW-1] ^ den_neg_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_a_ff <= '0;
         meta_b_ff <= '0;
      end else if (en) begin
         meta_a_ff <= sq_meta[RW];
         meta_b_ff <= meta_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_a_ff      <= x1_in;
         x2_a_ff      <= x2_in;
         den_a_ff     <= sq_den;
         den_neg_a_ff <= sq_den_neg;
         mag1_b_ff    <= mag1_in;
         mag2_b_ff    <= mag2_in;
         neg_b_ff     <= neg_in;
         den_b_ff     <= den_a_ff;
      end
   end

   // Division chain, both lanes sharing the denominator.
   qrs_pkg::meta_type dv_meta [0:NUMW];
   logic [1:0]        dv_neg  [0:NUMW];
   logic [DENW-1:0]   dv_den  [0:NUMW];
   logic [NUMW-1:0]   dv_num1 [0:NUMW];
   logic [NUMW-1:0]   dv_num2 [0:NUMW];
   logic [DENW-1:0]   dv_rem1 [0:NUMW];
   logic [DENW-1:0]   dv_rem2 [0:NUMW];
   logic [NUMW-1:0]   dv_q1   [0:NUMW];
   logic [NUMW-1:0]   dv_q2   [0:NUMW];

   assign dv_meta[0] = meta_b_ff;
   assign dv_neg[0]  = neg_b_ff;
   assign dv_den[0]  = den_b_ff;
   assign dv_num1[0] = mag1_b_ff;
   assign dv_num2[0] = mag2_b_ff;
   assign dv_rem1[0] = '0;
   assign dv_rem2[0] = '0;
   assign dv_q1[0]   = '0;
   assign dv_q2[0]   = '0;

   for (genvar j = 0; j < NUMW; j++) begin : g_div
      qrs_div_cell #(.NUMW(NUMW), .DENW(DENW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_meta   (dv_meta[j]),
         .up_neg    (dv_neg[j]),
         .up_den    (dv_den[j]),
         .up_num1   (dv_num1[j]),
         .up_num2   (dv_num2[j]),
         .up_rem1   (dv_rem1[j]),
         .up_rem2   (dv_rem2[j]),
         .up_q1     (dv_q1[j]),
         .up_q2     (dv_q2[j]),
         .down_meta (dv_meta[j+1]),
         .down_neg  (dv_neg[j+1]),
         .down_den  (dv_den[j+1]),
         .down_num1 (dv_num1[j+1]),
         .down_num2 (dv_num2[j+1]),
         .down_rem1 (dv_rem1[j+1]),
         .down_rem2 (dv_rem2[j+1]),
         .down_q1   (dv_q1[j+1]),
         .down_q2   (dv_q2[j+1])
      );
   end

   // Returns {clipped, root}: a negative quotient may reach the full negative limit.
   function automatic logic [W:0] sat_root(input logic [NUMW-1:0] q, input logic neg);
      logic clip;
      logic [W-1:0] low;
      low  = q[W-1:0];
      clip = neg ? (q > LIM) : (q >= LIM);
      if (neg) begin
         return clip ? {1'b1, 1'b1, {(W - 1){1'b0}}} : {1'b0, ~low + 1'b1};
      end
      return clip ? {1'b1, 1'b0, {(W - 1){1'b1}}} : {1'b0, low};
   endfunction

   qrs_pkg::meta_type fin_meta;
   logic [W:0]        fin1, fin2;
   logic              roots_ok;
   logic [1:0]        count_new;
   logic [RESW-1:0]   res_new;
   logic              res_valid;

   assign fin_meta = dv_meta[NUMW];
   assign fin1     = sat_root(dv_q1[NUMW], dv_neg[NUMW][1]);
   assign fin2     = sat_root(dv_q2[NUMW], dv_neg[NUMW][0]);
   assign roots_ok = (fin_meta.status == qrs_pkg::STATUS_TWO) ||
                     (fin_meta.status == qrs_pkg::STATUS_SINGLE);

   always_comb begin
      case (fin_meta.status)
         qrs_pkg::STATUS_TWO:    count_new = 2'd2;
         qrs_pkg::STATUS_SINGLE: count_new = 2'd1;
         default:                count_new = 2'd0;
      endcase
   end

   assign res_new = roots_ok ?
                    {fin1[W-1:0], fin2[W-1:0], count_new, fin_meta.status, fin1[W] | fin2[W]} :
                    {{(2 * W){1'b0}}, count_new, fin_meta.status, 1'b0};
   assign res_valid = fin_meta.valid & en;

   // Output register plus one skid entry.
   logic [RESW-1:0] rsp_ff, skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res_new;
      end else if (res_valid) begin
         skid_ff <= res_new;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_first  = rsp_ff[RESW-1 -: W];
   assign rsp_root_second = rsp_ff[RESW-W-1 -: W];
   assign rsp_root_count  = rsp_ff[4:3];
   assign rsp_status      = rsp_ff[2:1];
   assign rsp_saturated   = rsp_ff[0];

`ifndef ASSERT_OFF
   a_skid_needs_rsp: assert property (@(posedge clock) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register is empty");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_status == qrs_pkg::STATUS_TWO) == (rsp_root_count == 2'd2)))
      else $error("root count disagrees with status");

   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status == qrs_pkg::STATUS_NEG_DISC ||
                        rsp_status == qrs_pkg::STATUS_DEGEN))
      |-> (rsp_root_first == '0 && rsp_root_second == '0 && !rsp_saturated))
      else $error("rootless result carries roots or clip flag");

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid_ff && !skid_valid_ff)
      else $error("output not empty after reset");
`endif

endmodule
